// ===== src/tpbc_pkg.sv =====
`default_nettype none
package tpbc_pkg;

  localparam int unsigned LevelCount = 12;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned GainW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BandW      = 2;
  localparam int unsigned OutDataW   = 24;

  localparam logic [LevelW-1:0] LevelMax   = LevelW'(LevelCount - 1);
  localparam logic [LevelW-1:0] StartLevel = 4'd4;

  localparam logic [ByteW-1:0] InitByte = 8'h00;
  localparam logic [ByteW-1:0] TopByte  = 8'hCC;

  typedef enum logic [1:0] {
    STATUS_IGNORED = 2'd0,
    STATUS_LEVEL   = 2'd1,
    STATUS_INIT    = 2'd2
  } status_e;

  typedef enum logic [BandW-1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_e;

  typedef struct packed {
    status_e           status;
    logic [LevelW-1:0] level;
  } report_t;

  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [LevelW-1:0] level;
    logic              stepped;
    status_e           status;
  } result_t;

  function automatic logic [GainW-1:0] gain_lookup(input logic [LevelW-1:0] lvl);
    logic [GainW-1:0] g;
    unique case (lvl)
      4'd0:    g = 16'd6554;
      4'd1:    g = 16'd11338;
      4'd2:    g = 16'd16122;
      4'd3:    g = 16'd20840;
      4'd4:    g = 16'd25625;
      4'd5:    g = 16'd30409;
      4'd6:    g = 16'd35127;
      4'd7:    g = 16'd39911;
      4'd8:    g = 16'd44696;
      4'd9:    g = 16'd49480;
      4'd10:   g = 16'd54198;
      4'd11:   g = 16'd58982;
      default: g = 16'd6554;
    endcase
    return g;
  endfunction

  function automatic report_t decode_byte(input logic [ByteW-1:0] b);
    report_t r;
    r.status = STATUS_IGNORED;
    r.level  = '0;
    if (b == InitByte) begin
      r.status = STATUS_INIT;
    end else if ((b[7:4] == b[3:0]) && (b <= TopByte)) begin
      r.status = STATUS_LEVEL;
      r.level  = b[7:4] - 4'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/tpbc_in_stage.sv =====
`default_nettype none
module tpbc_in_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [tpbc_pkg::ByteW-1:0] s_axis_tdata,
  input  wire logic                     advance_i,
  output logic                          rpt_valid_o,
  output tpbc_pkg::report_t             rpt_o
);
  import tpbc_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             accept;

  assign s_axis_tready = !valid_q || advance_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (accept) begin
      valid_d = 1'b1;
      byte_d  = s_axis_tdata;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign rpt_valid_o = valid_q;
  assign rpt_o       = decode_byte(byte_q);

endmodule
`default_nettype wire

// ===== src/tpbc_level_ctrl.sv =====
`default_nettype none
module tpbc_level_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tpbc_pkg::BandW-1:0] cfg_wdata_i,
  input  wire logic                       rpt_valid_i,
  input  wire tpbc_pkg::report_t          rpt_i,
  output logic                            advance_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output tpbc_pkg::result_t               res_o
);
  import tpbc_pkg::*;

  logic [BandW-1:0]  band_q, band_d;
  logic [LevelW-1:0] tx_level_q, tx_level_d;
  logic              started_q, started_d;
  logic [LevelW-1:0] last_level_q, last_level_d;
  logic              last_valid_q, last_valid_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic [LevelW-1:0] before_lvl, lvl, lo, hi;

  assign advance_o = rpt_valid_i && (!out_valid_q || res_ready_i);

  always_comb begin
    unique case (band_q)
      BAND_LOW:  begin lo = 4'd0; hi = 4'd3;  end
      BAND_HIGH: begin lo = 4'd8; hi = 4'd11; end
      default:   begin lo = 4'd4; hi = 4'd7;  end
    endcase
  end

  always_comb begin
    band_d       = band_q;
    tx_level_d   = tx_level_q;
    started_d    = started_q;
    last_level_d = last_level_q;
    last_valid_d = last_valid_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    res_d        = res_q;
    before_lvl   = started_q ? tx_level_q : StartLevel;
    lvl          = before_lvl;

    if (advance_o) begin
      if (rpt_i.status != STATUS_IGNORED) begin
        started_d = 1'b1;
      end
      if (rpt_i.status == STATUS_LEVEL &&
          (!last_valid_q || last_level_q != rpt_i.level)) begin
        last_level_d = rpt_i.level;
        last_valid_d = 1'b1;
        if (rpt_i.level < lo) begin
          if (lvl != LevelMax) lvl = lvl + 4'd1;
        end else if (rpt_i.level > hi) begin
          if (lvl != '0) lvl = lvl - 4'd1;
        end
      end
      if (rpt_i.status != STATUS_IGNORED) begin
        tx_level_d = lvl;
      end else begin
        lvl = before_lvl;
      end
      out_valid_d   = 1'b1;
      res_d.gain    = gain_lookup(lvl);
      res_d.level   = lvl;
      res_d.stepped = (lvl != before_lvl);
      res_d.status  = rpt_i.status;
    end

    if (cfg_we_i) begin
      band_d     = cfg_wdata_i;
      started_d  = 1'b0;
      tx_level_d = StartLevel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q       <= BAND_MID;
      tx_level_q   <= StartLevel;
      started_q    <= 1'b0;
      last_level_q <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      band_q       <= band_d;
      tx_level_q   <= tx_level_d;
      started_q    <= started_d;
      last_level_q <= last_level_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.level <= LevelMax)
    else $error("result level out of range");

  a_unstarted_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> tx_level_q == StartLevel)
    else $error("level moved while uninitialized");

  a_ignored_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && rpt_i.status == STATUS_IGNORED |=> !res_q.stepped)
    else $error("ignored byte stepped the level");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o |=> out_valid_q)
    else $error("result lost after advance");

endmodule
`default_nettype wire

// ===== src/tx_power_band_controller.sv =====
`default_nettype none
// Transmit power band controller. Each input transaction carries the first byte of a
// feedback message; 0x11*(n+1) reports level n (0..11), 0x00 is an init report and any
// other byte is ignored. The first level or init report starts the transmit level at 4;
// level reports that differ from the previous one, or have none before them, step it toward the band
// set by cfg_wdata_i (0 low, 1 mid, 2 high, 3 acts as mid), saturating at 0 and 11. A band write
// returns the level to its uninitialized state (shown as 4). Every input transaction
// yields exactly one output transaction with the Q0.16 gain of the current level. The
// block takes one transaction per cycle while m_axis_tready does not hold results back: an input
// register feeds the decode and level update, which load the result register.
module tx_power_band_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpbc_pkg::BandW-1:0]    cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [tpbc_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] report_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] gain_q16, [19:16] power_level, [20] stepped, [23:21] zero
  output logic [tpbc_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [1:0]                         m_axis_tuser   // [1:0] report_status
);
  import tpbc_pkg::*;

  logic    advance;
  logic    rpt_valid;
  report_t rpt;
  result_t res;

  tpbc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .rpt_valid_o   (rpt_valid),
    .rpt_o         (rpt)
  );

  tpbc_level_ctrl u_level_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rpt_valid_i (rpt_valid),
    .rpt_i       (rpt),
    .advance_o   (advance),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.stepped, res.level, res.gain};
  assign m_axis_tuser = res.status;

endmodule
`default_nettype wire
